// ----- rtl/srr_pkg.sv -----
// ----------------------------------------------------------------------------
// srr_pkg
// Shared widths, register codes and reset values of the rectification remap.
// ----------------------------------------------------------------------------
package srr_pkg;

  localparam int PIX_W   = 12;  // pixel column / row
  localparam int CF_W    = 18;  // Q2.16 rotation coefficient
  localparam int F_W     = 24;  // Q16.8 focal length / center
  localparam int ROW_W   = 3 * CF_W;
  localparam int PAIR_W  = 2 * F_W;
  localparam int NUM_W   = 26;  // pixel*256 - c, signed
  localparam int RQ_W    = 44;  // ray quotient magnitude, Q.20
  localparam int RAY_W   = RQ_W + 1;
  localparam int PROD_W  = CF_W + RAY_W;
  localparam int ROT_W   = 64;  // rotated component, Q.36
  localparam int MAG_W   = 63;
  localparam int N_W     = MAG_W + F_W;
  localparam int PQ_W    = 41;  // projected quotient, clipped at 2^40
  localparam int OUT_W   = 32;
  localparam int IDX_W   = 3;

  localparam logic [PQ_W-1:0]  QUOT_CLIP = PQ_W'(64'h100_0000_0000);
  localparam logic [MAG_W-1:0] Z_MIN     = MAG_W'(64'h1_0000);

  localparam logic [ROW_W-1:0]  ROT0_RST  = ROW_W'(64'h1_0000);
  localparam logic [ROW_W-1:0]  ROT1_RST  = ROW_W'(64'h4_0000_0000);
  localparam logic [ROW_W-1:0]  ROT2_RST  = ROW_W'(64'h10_0000_0000_0000);
  localparam logic [PAIR_W-1:0] FOCAL_RST = PAIR_W'(64'h0001_0000_0100);

  typedef enum logic [IDX_W-1:0] {
    REG_ROT0        = 3'd0,
    REG_ROT1        = 3'd1,
    REG_ROT2        = 3'd2,
    REG_ORIG_FOCAL  = 3'd3,
    REG_ORIG_CENTER = 3'd4,
    REG_RECT_FOCAL  = 3'd5,
    REG_RECT_CENTER = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic clip;
    logic neg;
  } proj_side_t;

endpackage

// ----- rtl/srr_div_pipe.sv -----
// ----------------------------------------------------------------------------
// srr_div_pipe
// Pipelined restoring divider, one quotient bit per register stage.
// Expects num >> QW below den; the quotient then fits in QW bits.
// ----------------------------------------------------------------------------
module srr_div_pipe #(
  parameter int NW = 44,
  parameter int DW = 24,
  parameter int QW = 44,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  logic          vld  [QW];
  logic [DW-1:0] rem  [QW];
  logic [QW-1:0] nlo  [QW];
  logic [DW-1:0] dv   [QW];
  logic [QW-1:0] qq   [QW];
  logic [SW-1:0] sd   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] r_in;
    logic [QW-1:0] n_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic [SW-1:0] s_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      always_comb begin
        v_in = in_valid;
        r_in = DW'(num >> QW);
        n_in = num[QW-1:0];
        d_in = den;
        q_in = '0;
        s_in = side_in;
      end
    end else begin : g_next
      always_comb begin
        v_in = vld[k-1];
        r_in = rem[k-1];
        n_in = nlo[k-1];
        d_in = dv[k-1];
        q_in = qq[k-1];
        s_in = sd[k-1];
      end
    end

    always_comb begin
      trial = {r_in, n_in[QW-1]};
      diff  = trial - {1'b0, d_in};
      ge    = trial >= {1'b0, d_in};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= v_in;
      end
      if (adv) begin
        rem[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        nlo[k] <= n_in << 1;
        dv[k]  <= d_in;
        qq[k]  <= {q_in[QW-2:0], ge};
        sd[k]  <= s_in;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quo       = qq[QW-1];
  assign side_out  = sd[QW-1];

endmodule

// ----- rtl/srr_ray_gen.sv -----
// ----------------------------------------------------------------------------
// srr_ray_gen
// Normalized ray of the original camera: (pix*256 - c) * 2^20 / f in Q.20.
// ----------------------------------------------------------------------------
module srr_ray_gen (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               in_valid,
  input  logic [srr_pkg::PIX_W-1:0]          pixel_col,
  input  logic [srr_pkg::PIX_W-1:0]          pixel_row,
  input  logic [srr_pkg::PAIR_W-1:0]         orig_focal,
  input  logic [srr_pkg::PAIR_W-1:0]         orig_center,
  output logic                               out_valid,
  output logic signed [srr_pkg::RAY_W-1:0]   ray_x,
  output logic signed [srr_pkg::RAY_W-1:0]   ray_y
);

  localparam int NW = srr_pkg::NUM_W;
  localparam int FW = srr_pkg::F_W;
  localparam int QW = srr_pkg::RQ_W;

  logic signed [NW-1:0] num_x, num_y;
  logic [NW-1:0]        abs_x, abs_y;
  logic [FW-1:0]        fx, fy;

  logic          a_vld;
  logic [QW-1:0] a_nx, a_ny;
  logic [FW-1:0] a_dx, a_dy;
  logic          a_sx, a_sy;

  logic          dx_vld, dy_vld;
  logic [QW-1:0] qx, qy;
  logic          sx, sy;

  always_comb begin
    num_x = signed'({6'b0, pixel_col, 8'b0}) - signed'({2'b0, orig_center[FW-1:0]});
    num_y = signed'({6'b0, pixel_row, 8'b0}) - signed'({2'b0, orig_center[2*FW-1:FW]});
    abs_x = num_x[NW-1] ? NW'(-num_x) : NW'(num_x);
    abs_y = num_y[NW-1] ? NW'(-num_y) : NW'(num_y);
    fx    = orig_focal[FW-1:0];
    fy    = orig_focal[2*FW-1:FW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= in_valid;
    end
    if (adv) begin
      a_nx <= {abs_x[FW-1:0], 20'b0};
      a_ny <= {abs_y[FW-1:0], 20'b0};
      // zero focal length counts as one LSB
      a_dx <= (fx == '0) ? FW'(1) : fx;
      a_dy <= (fy == '0) ? FW'(1) : fy;
      a_sx <= num_x[NW-1];
      a_sy <= num_y[NW-1];
    end
  end

  srr_div_pipe #(.NW(QW), .DW(FW), .QW(QW), .SW(1)) u_div_x (
    .clk, .rst, .adv,
    .in_valid (a_vld), .num (a_nx), .den (a_dx), .side_in (a_sx),
    .out_valid(dx_vld), .quo (qx), .side_out (sx)
  );

  srr_div_pipe #(.NW(QW), .DW(FW), .QW(QW), .SW(1)) u_div_y (
    .clk, .rst, .adv,
    .in_valid (a_vld), .num (a_ny), .den (a_dy), .side_in (a_sy),
    .out_valid(dy_vld), .quo (qy), .side_out (sy)
  );

  assign out_valid = dx_vld & dy_vld;
  assign ray_x = sx ? -signed'({1'b0, qx}) : signed'({1'b0, qx});
  assign ray_y = sy ? -signed'({1'b0, qy}) : signed'({1'b0, qy});

endmodule

// ----- rtl/srr_rotate.sv -----
// ----------------------------------------------------------------------------
// srr_rotate
// Rotate the ray by the rectification matrix and condition the z divisor.
// ----------------------------------------------------------------------------
module srr_rotate (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic signed [srr_pkg::RAY_W-1:0]  ray_x,
  input  logic signed [srr_pkg::RAY_W-1:0]  ray_y,
  input  logic [srr_pkg::ROW_W-1:0]         rot_row0,
  input  logic [srr_pkg::ROW_W-1:0]         rot_row1,
  input  logic [srr_pkg::ROW_W-1:0]         rot_row2,
  output logic                              out_valid,
  output logic [srr_pkg::MAG_W-1:0]         mag_x,
  output logic [srr_pkg::MAG_W-1:0]         mag_y,
  output logic [srr_pkg::MAG_W-1:0]         zmag,
  output logic                              neg_x,
  output logic                              neg_y
);

  localparam int CW = srr_pkg::CF_W;
  localparam int PW = srr_pkg::PROD_W;
  localparam int RW = srr_pkg::ROT_W;
  localparam int MW = srr_pkg::MAG_W;

  localparam logic [MW-1:0] Z_MIN_LOCAL = srr_pkg::Z_MIN;

  logic signed [CW-1:0] coef [3][3];
  logic signed [PW-1:0] prod [3][2];
  logic signed [RW-1:0] rsum [3];
  logic signed [RW-1:0] rot_nx [3];
  logic [RW-1:0]        abs_r [3];
  logic                 small_z;
  logic                 zneg;

  logic m_vld, s_vld;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      coef[0][c] = signed'(rot_row0[CW*c +: CW]);
      coef[1][c] = signed'(rot_row1[CW*c +: CW]);
      coef[2][c] = signed'(rot_row2[CW*c +: CW]);
    end
    for (int r = 0; r < 3; r++) begin
      rot_nx[r] = RW'(prod[r][0]) + RW'(prod[r][1]) + (RW'(coef[r][2]) <<< 20);
      abs_r[r]  = rsum[r][RW-1] ? RW'(-rsum[r]) : RW'(rsum[r]);
    end
    small_z = abs_r[2][MW-1:0] < Z_MIN_LOCAL;
    zneg    = rsum[2][RW-1] & ~small_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld     <= 1'b0;
      s_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      m_vld     <= in_valid;
      s_vld     <= m_vld;
      out_valid <= s_vld;
    end
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        prod[r][0] <= coef[r][0] * ray_x;
        prod[r][1] <= coef[r][1] * ray_y;
        rsum[r]    <= rot_nx[r];
      end
      mag_x <= abs_r[0][MW-1:0];
      mag_y <= abs_r[1][MW-1:0];
      // clamp a vanishing z to +1 LSB of Q.20
      zmag  <= small_z ? Z_MIN_LOCAL : abs_r[2][MW-1:0];
      neg_x <= rsum[0][RW-1] ^ zneg;
      neg_y <= rsum[1][RW-1] ^ zneg;
    end
  end

endmodule

// ----- rtl/srr_project.sv -----
// ----------------------------------------------------------------------------
// srr_project
// Scale by the rectified focal length, divide by z, add the center, saturate.
// ----------------------------------------------------------------------------
module srr_project (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               in_valid,
  input  logic [srr_pkg::MAG_W-1:0]          mag_x,
  input  logic [srr_pkg::MAG_W-1:0]          mag_y,
  input  logic [srr_pkg::MAG_W-1:0]          zmag,
  input  logic                               neg_x,
  input  logic                               neg_y,
  input  logic [srr_pkg::PAIR_W-1:0]         rect_focal,
  input  logic [srr_pkg::PAIR_W-1:0]         rect_center,
  output logic                               out_valid,
  output logic signed [srr_pkg::OUT_W-1:0]   map_x,
  output logic signed [srr_pkg::OUT_W-1:0]   map_y
);

  localparam int FW = srr_pkg::F_W;
  localparam int MW = srr_pkg::MAG_W;
  localparam int NW = srr_pkg::N_W;
  localparam int QW = srr_pkg::PQ_W;
  localparam int OW = srr_pkg::OUT_W;
  localparam int SW = $bits(srr_pkg::proj_side_t);
  localparam int LW = 32;
  localparam int HW = MW - LW;
  localparam int SUM_W = QW + 2;

  logic [FW-1:0] fx, fy;

  // partial products, low and high halves of the magnitude
  logic              p1_vld;
  logic [LW+FW-1:0]  plo_x, plo_y;
  logic [HW+FW-1:0]  phi_x, phi_y;
  logic [MW-1:0]     p1_z;
  logic              p1_nx, p1_ny;

  logic [NW-1:0]     n_x, n_y;
  logic              p2_vld;
  logic [NW-1:0]     p2_nx, p2_ny;
  logic [MW-1:0]     p2_z;
  srr_pkg::proj_side_t p2_sx, p2_sy;

  logic              dx_vld, dy_vld;
  logic [QW-1:0]     qx, qy;
  logic [SW-1:0]     sdx, sdy;
  srr_pkg::proj_side_t ox, oy;

  logic signed [OW-1:0] res_x, res_y;

  function automatic logic signed [OW-1:0] finish(input logic [QW-1:0] q,
                                                  input srr_pkg::proj_side_t sd,
                                                  input logic [FW-1:0] c);
    logic [QW-1:0]          qc;
    logic signed [SUM_W-1:0] sv;
    logic signed [SUM_W-1:0] s;
    qc = (sd.clip || q > srr_pkg::QUOT_CLIP) ? srr_pkg::QUOT_CLIP : q;
    sv = signed'({2'b0, qc});
    if (sd.neg) sv = -sv;
    s = sv + signed'(SUM_W'(c));
    if (s > signed'(SUM_W'(32'h7FFF_FFFF))) begin
      finish = {1'b0, {(OW-1){1'b1}}};
    end else if (s < -signed'(SUM_W'(33'h0_8000_0000))) begin
      finish = {1'b1, {(OW-1){1'b0}}};
    end else begin
      finish = s[OW-1:0];
    end
  endfunction

  always_comb begin
    fx  = rect_focal[FW-1:0];
    fy  = rect_focal[2*FW-1:FW];
    n_x = (NW'(phi_x) << LW) + NW'(plo_x);
    n_y = (NW'(phi_y) << LW) + NW'(plo_y);
    ox  = srr_pkg::proj_side_t'(sdx);
    oy  = srr_pkg::proj_side_t'(sdy);
    res_x = finish(qx, ox, rect_center[FW-1:0]);
    res_y = finish(qy, oy, rect_center[2*FW-1:FW]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld    <= 1'b0;
      p2_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      p1_vld    <= in_valid;
      p2_vld    <= p1_vld;
      out_valid <= dx_vld & dy_vld;
    end
    if (adv) begin
      plo_x <= mag_x[LW-1:0] * fx;
      phi_x <= mag_x[MW-1:LW] * fx;
      plo_y <= mag_y[LW-1:0] * fy;
      phi_y <= mag_y[MW-1:LW] * fy;
      p1_z  <= zmag;
      p1_nx <= neg_x;
      p1_ny <= neg_y;

      p2_nx      <= n_x;
      p2_ny      <= n_y;
      p2_z       <= p1_z;
      // quotient of 2^41 or more saturates; skip the divide result
      p2_sx.clip <= MW'(n_x >> QW) >= p1_z;
      p2_sx.neg  <= p1_nx;
      p2_sy.clip <= MW'(n_y >> QW) >= p1_z;
      p2_sy.neg  <= p1_ny;

      map_x <= res_x;
      map_y <= res_y;
    end
  end

  srr_div_pipe #(.NW(NW), .DW(MW), .QW(QW), .SW(SW)) u_div_x (
    .clk, .rst, .adv,
    .in_valid (p2_vld), .num (p2_nx), .den (p2_z), .side_in (p2_sx),
    .out_valid(dx_vld), .quo (qx), .side_out (sdx)
  );

  srr_div_pipe #(.NW(NW), .DW(MW), .QW(QW), .SW(SW)) u_div_y (
    .clk, .rst, .adv,
    .in_valid (p2_vld), .num (p2_ny), .den (p2_z), .side_in (p2_sy),
    .out_valid(dy_vld), .quo (qy), .side_out (sdy)
  );

endmodule

// ----- rtl/stereo_rectify_remap_grid.sv -----
// ----------------------------------------------------------------------------
// stereo_rectify_remap_grid
// Rectification remap map generator without lens distortion.
// ----------------------------------------------------------------------------
// Takes one pixel coordinate per clock and returns its source map coordinate
// in signed Q24.8 at one result per clock. Most of the depth lies in the
// two bit-per-stage restoring dividers (44 stages for the normalized ray,
// 41 stages for the division by z); the whole pipeline holds while the
// output transfer is stalled. Configuration registers take effect on items
// accepted after the write; write them only while the pipeline is empty.
module stereo_rectify_remap_grid (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [23:0]                 s_tdata,   // pixel_col[11:0], pixel_row[23:12]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [63:0]                 m_tdata,   // map_x[31:0], map_y[63:32]
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [srr_pkg::IDX_W-1:0]   cfg_index,
  input  logic [srr_pkg::ROW_W-1:0]   cfg_data
);

  localparam int PW = srr_pkg::PAIR_W;

  logic [srr_pkg::ROW_W-1:0] rot_row0, rot_row1, rot_row2;
  logic [PW-1:0] orig_focal, orig_center, rect_focal, rect_center;

  logic adv;
  logic ray_vld, rot_vld;
  logic signed [srr_pkg::RAY_W-1:0] ray_x, ray_y;
  logic [srr_pkg::MAG_W-1:0] mag_x, mag_y, zmag;
  logic neg_x, neg_y;
  logic signed [srr_pkg::OUT_W-1:0] map_x, map_y;

  // advance the whole pipeline unless a result waits at the output
  assign adv       = ~m_tvalid | m_tready;
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {map_y, map_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row0    <= srr_pkg::ROT0_RST;
      rot_row1    <= srr_pkg::ROT1_RST;
      rot_row2    <= srr_pkg::ROT2_RST;
      orig_focal  <= srr_pkg::FOCAL_RST;
      orig_center <= '0;
      rect_focal  <= srr_pkg::FOCAL_RST;
      rect_center <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        srr_pkg::REG_ROT0:        rot_row0    <= cfg_data;
        srr_pkg::REG_ROT1:        rot_row1    <= cfg_data;
        srr_pkg::REG_ROT2:        rot_row2    <= cfg_data;
        srr_pkg::REG_ORIG_FOCAL:  orig_focal  <= cfg_data[PW-1:0];
        srr_pkg::REG_ORIG_CENTER: orig_center <= cfg_data[PW-1:0];
        srr_pkg::REG_RECT_FOCAL:  rect_focal  <= cfg_data[PW-1:0];
        srr_pkg::REG_RECT_CENTER: rect_center <= cfg_data[PW-1:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  srr_ray_gen u_ray (
    .clk, .rst, .adv,
    .in_valid   (s_tvalid & s_tready),
    .pixel_col  (s_tdata[11:0]),
    .pixel_row  (s_tdata[23:12]),
    .orig_focal, .orig_center,
    .out_valid  (ray_vld),
    .ray_x, .ray_y
  );

  srr_rotate u_rot (
    .clk, .rst, .adv,
    .in_valid  (ray_vld),
    .ray_x, .ray_y,
    .rot_row0, .rot_row1, .rot_row2,
    .out_valid (rot_vld),
    .mag_x, .mag_y, .zmag, .neg_x, .neg_y
  );

  srr_project u_proj (
    .clk, .rst, .adv,
    .in_valid  (rot_vld),
    .mag_x, .mag_y, .zmag, .neg_x, .neg_y,
    .rect_focal, .rect_center,
    .out_valid (m_tvalid),
    .map_x, .map_y
  );

endmodule

// ----- rtl/srr_checker.sv -----
// ----------------------------------------------------------------------------
// srr_checker
// Port-level checks of the remap pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module srr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        cfg_ready
);

  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_ready_empty : assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  a_cfg_ready : assert property (@(posedge clk) cfg_ready)
    else $error("config port not ready");

  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result present after reset");

endmodule

bind stereo_rectify_remap_grid srr_checker u_srr_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_ready (cfg_ready)
);
